// ===== rtl/beta_carbon_placement_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BETA_CARBON_PLACEMENT_TOP_ASSERT_SVH
`define BETA_CARBON_PLACEMENT_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define CBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define CBP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/cbp_pkg.sv =====
package cbp_pkg;

    // Coordinates carry 10 fractional bits; the scale only matters to the user.
    localparam int COORD_WIDTH = 22;
    localparam int DW          = COORD_WIDTH + 1;           // backbone difference
    localparam int SW          = COORD_WIDTH + 2;           // sum vector
    localparam int XW          = (DW < 31) ? DW : 31;       // difference after range shift
    localparam int PW          = 2 * XW + 1;                // cross product
    localparam int MW          = 30;                        // normalized magnitude bits
    localparam int LW          = $clog2(PW + 1);
    localparam int BOND_W      = 12;
    localparam int K_W         = 16;
    localparam int KK_W        = BOND_W + K_W;
    localparam int SQ_W        = 2 * MW + 2;
    localparam int LEN_W       = MW + 1;
    localparam int NUM_W       = MW + KK_W + 1;
    localparam int DEN_W       = LEN_W + K_W;
    localparam int QW          = BOND_W;
    localparam int RES_W       = COORD_WIDTH + 2;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam int SQRT_STAGES  = SQ_W / 2;
    localparam int FRONT_STAGES = 4;
    localparam int NORM_STAGES  = 2;
    localparam int OFS_STAGES   = 4 + SQRT_STAGES + QW;
    localparam int ALIGN        = FRONT_STAGES + NORM_STAGES + OFS_STAGES;
    localparam int LAT          = ALIGN + 2;

    localparam logic [K_W-1:0]    COS_Q16    = 16'd37837;
    localparam logic [K_W-1:0]    SIN_Q16    = 16'd53510;
    localparam logic [BOND_W-1:0] BOND_RESET = 12'd1567;

    localparam logic [ADDR_W-3:0] REG_BOND_LENGTH = '0;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [SW-1:0]          sum_t;
    typedef logic signed [PW-1:0]          pvec_t;
    typedef logic signed [QW:0]            off_t;
    typedef logic signed [RES_W-1:0]       res_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][MW-1:0]   mag;
    } nvec_t;

    function automatic logic [LW-1:0] bit_len(input logic [PW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < PW; i++) begin
            if (v[i])
            begin
                n = LW'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/beta_carbon_placement_top.sv =====
// A result strobes on done after the front, norm, offset, add and saturate stages.
// Throughput: one residue per cycle; busy stays low, so start may be held high.
// The depth comes from the 31-stage square root and 12-stage dividers per vector.
// The receiver cannot stall: each result shows for exactly one cycle on done.
// Reset (rst_n low, asynchronous) empties the pipeline and sets bond_length to 1567.
module beta_carbon_placement_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cbp_pkg::coord_t              n_x,
    input  cbp_pkg::coord_t              n_y,
    input  cbp_pkg::coord_t              n_z,
    input  cbp_pkg::coord_t              ca_x,
    input  cbp_pkg::coord_t              ca_y,
    input  cbp_pkg::coord_t              ca_z,
    input  cbp_pkg::coord_t              c_x,
    input  cbp_pkg::coord_t              c_y,
    input  cbp_pkg::coord_t              c_z,
    output logic                         done,
    output cbp_pkg::coord_t              cb_x,
    output cbp_pkg::coord_t              cb_y,
    output cbp_pkg::coord_t              cb_z,
    output logic                         degenerate,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbp_pkg::DATA_W-1:0]   pwdata,
    output logic [cbp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import cbp_pkg::*;

    localparam int DEG_FIRST = FRONT_STAGES + NORM_STAGES;

    coord_t              n_v  [3];
    coord_t              ca_v [3];
    coord_t              c_v  [3];
    pvec_t               p_f  [3];
    sum_t                s_f  [3];
    pvec_t               s_ext [3];
    nvec_t               s_n;
    nvec_t               p_n;
    off_t                off_s [3];
    off_t                off_p [3];

    logic [BOND_W-1:0]   bond_reg;
    logic [BOND_W-1:0]   bond_next;
    logic [KK_W-1:0]     kk_cos_reg;
    logic [KK_W-1:0]     kk_sin_reg;
    logic                cfg_wr;

    logic                vld_reg [0:ALIGN-1];
    coord_t              ca_q    [0:ALIGN-1][3];
    logic                deg_q   [DEG_FIRST:ALIGN-1];

    res_t                sum_next [3];
    res_t                sum_reg  [3];
    logic                deg_t_reg;
    logic                vld_t_reg;
    coord_t              cb_next [3];
    coord_t              cb_reg  [3];
    logic                degen_reg;
    logic                done_reg;

    // The pipeline never pushes back: a beat enters whenever start is high.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Configuration: bond_length is the only register, at byte address 0.
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        bond_next = bond_reg;
        if (cfg_wr && (paddr[ADDR_W-1:2] == REG_BOND_LENGTH))
        begin
            bond_next = pwdata[BOND_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_BOND_LENGTH: prdata = DATA_W'(bond_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bond_reg <= BOND_RESET;
        end
        else
        begin
            bond_reg <= bond_next;
        end
    end

    // Hold bond*cos, bond*sin; user changes config only with pipe empty; no check.
    always_ff @(posedge clk)
    begin
        kk_cos_reg <= bond_reg * COS_Q16;
        kk_sin_reg <= bond_reg * SIN_Q16;
    end

    assign n_v[0]  = n_x;
    assign n_v[1]  = n_y;
    assign n_v[2]  = n_z;
    assign ca_v[0] = ca_x;
    assign ca_v[1] = ca_y;
    assign ca_v[2] = ca_z;
    assign c_v[0]  = c_x;
    assign c_v[1]  = c_y;
    assign c_v[2]  = c_z;

    // Difference, range shift and cross product stages.
    cbp_front u_front (
        .clk (clk),
        .n   (n_v),
        .ca  (ca_v),
        .c   (c_v),
        .p   (p_f),
        .s   (s_f)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            s_ext[i] = PW'(s_f[i]);
        end
    end

    // Normalize both direction vectors in parallel.
    cbp_norm u_norm_s (
        .clk (clk),
        .v   (s_ext),
        .o   (s_n)
    );

    cbp_norm u_norm_p (
        .clk (clk),
        .v   (p_f),
        .o   (p_n)
    );

    // Length, scale and divide: cosine share along the sum, sine along the cross.
    cbp_offset u_offset_s (
        .clk (clk),
        .v   (s_n),
        .kk  (kk_cos_reg),
        .off (off_s)
    );

    cbp_offset u_offset_p (
        .clk (clk),
        .v   (p_n),
        .kk  (kk_sin_reg),
        .off (off_p)
    );

    // Valid bits travel alongside the data path; clear them on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ALIGN; k++) begin
                vld_reg[k] <= 1'b0;
            end
            vld_t_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int k = 1; k < ALIGN; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vld_t_reg <= vld_reg[ALIGN-1];
            done_reg  <= vld_t_reg;
        end
    end

    // Carry CA down to the final add, and the degenerate flag from the normalizers.
    always_ff @(posedge clk)
    begin
        ca_q[0] <= ca_v;
        for (int k = 1; k < ALIGN; k++) begin
            ca_q[k] <= ca_q[k-1];
        end
        deg_q[DEG_FIRST] <= s_n.zero | p_n.zero;
        for (int k = DEG_FIRST + 1; k < ALIGN; k++) begin
            deg_q[k] <= deg_q[k-1];
        end
    end

    // Final add: CA plus both offsets, or CA alone for a degenerate residue.
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (deg_q[ALIGN-1])
            begin
                sum_next[i] = RES_W'(ca_q[ALIGN-1][i]);
            end
            else
            begin
                sum_next[i] = RES_W'(ca_q[ALIGN-1][i]) + RES_W'(off_s[i]) + RES_W'(off_p[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        deg_t_reg <= deg_q[ALIGN-1];
    end

    // Saturate to the coordinate range and drive the result beat.
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (sum_reg[i] > RES_W'(COORD_MAX))
            begin
                cb_next[i] = COORD_MAX;
            end
            else if (sum_reg[i] < RES_W'(COORD_MIN))
            begin
                cb_next[i] = COORD_MIN;
            end
            else
            begin
                cb_next[i] = coord_t'(sum_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cb_reg    <= cb_next;
        degen_reg <= deg_t_reg;
    end

    assign done       = done_reg;
    assign cb_x       = cb_reg[0];
    assign cb_y       = cb_reg[1];
    assign cb_z       = cb_reg[2];
    assign degenerate = degen_reg;

endmodule

// ===== rtl/cbp_front.sv =====
module cbp_front (
    input  logic            clk,
    input  cbp_pkg::coord_t n  [3],
    input  cbp_pkg::coord_t ca [3],
    input  cbp_pkg::coord_t c  [3],
    output cbp_pkg::pvec_t  p  [3],
    output cbp_pkg::sum_t   s  [3]
);
    import cbp_pkg::*;

    typedef logic signed [DW-1:0]     diff_t;
    typedef logic signed [XW-1:0]     xv_t;
    typedef logic signed [2*XW-1:0]   prod_t;

    diff_t         a_reg [3];
    diff_t         b_reg [3];
    sum_t          s1_reg [3];
    sum_t          s2_reg [3];
    sum_t          s3_reg [3];
    sum_t          s4_reg [3];
    logic [DW-1:0] ma [3];
    logic [DW-1:0] mb [3];
    logic [DW-1:0] ma_sh [3];
    logic [DW-1:0] mb_sh [3];
    logic [DW-1:0] mor;
    logic [LW-1:0] alen;
    logic [LW-1:0] shr;
    xv_t           a_next [3];
    xv_t           b_next [3];
    xv_t           a2_reg [3];
    xv_t           b2_reg [3];
    prod_t         prod_reg [6];
    pvec_t         p_reg [3];

    // Stage 1: backbone differences and their sum.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            a_reg[i]  <= DW'(ca[i]) - DW'(n[i]);
            b_reg[i]  <= DW'(ca[i]) - DW'(c[i]);
            s1_reg[i] <= SW'(ca[i]) + SW'(ca[i]) - SW'(n[i]) - SW'(c[i]);
        end
    end

    // Stage 2: bring wide differences below 2^30 on magnitude.
    always_comb
    begin
        mor = '0;
        for (int i = 0; i < 3; i++) begin
            ma[i] = a_reg[i][DW-1] ? (~a_reg[i] + 1'b1) : a_reg[i];
            mb[i] = b_reg[i][DW-1] ? (~b_reg[i] + 1'b1) : b_reg[i];
            mor   = mor | ma[i] | mb[i];
        end
        alen = bit_len(PW'(mor));
        shr  = (alen > LW'(MW)) ? (alen - LW'(MW)) : '0;
        for (int i = 0; i < 3; i++) begin
            ma_sh[i]  = ma[i] >> shr;
            mb_sh[i]  = mb[i] >> shr;
            a_next[i] = a_reg[i][DW-1] ? (~xv_t'(ma_sh[i][XW-1:0]) + 1'b1)
                                       : xv_t'(ma_sh[i][XW-1:0]);
            b_next[i] = b_reg[i][DW-1] ? (~xv_t'(mb_sh[i][XW-1:0]) + 1'b1)
                                       : xv_t'(mb_sh[i][XW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        a2_reg <= a_next;
        b2_reg <= b_next;
        s2_reg <= s1_reg;
    end

    // Stage 3: cross product terms.
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= a2_reg[1] * b2_reg[2];
        prod_reg[1] <= a2_reg[2] * b2_reg[1];
        prod_reg[2] <= a2_reg[2] * b2_reg[0];
        prod_reg[3] <= a2_reg[0] * b2_reg[2];
        prod_reg[4] <= a2_reg[0] * b2_reg[1];
        prod_reg[5] <= a2_reg[1] * b2_reg[0];
        s3_reg      <= s2_reg;
    end

    // Stage 4: cross product.
    always_ff @(posedge clk)
    begin
        p_reg[0] <= PW'(prod_reg[0]) - PW'(prod_reg[1]);
        p_reg[1] <= PW'(prod_reg[2]) - PW'(prod_reg[3]);
        p_reg[2] <= PW'(prod_reg[4]) - PW'(prod_reg[5]);
        s4_reg   <= s3_reg;
    end

    assign p = p_reg;
    assign s = s4_reg;

endmodule

// ===== rtl/cbp_norm.sv =====
module cbp_norm (
    input  logic           clk,
    input  cbp_pkg::pvec_t v [3],
    output cbp_pkg::nvec_t o
);
    import cbp_pkg::*;

    logic [PW-1:0] mag_next [3];
    logic [PW-1:0] mag_reg [3];
    logic [PW-1:0] shv [3];
    logic [PW-1:0] mor;
    logic [2:0]    neg_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] sh;
    nvec_t         o_next;
    nvec_t         o_reg;

    // Stage A: magnitudes and bit length of the largest one.
    always_comb
    begin
        mor = '0;
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = v[i][PW-1] ? (~v[i] + 1'b1) : v[i];
            mor         = mor | mag_next[i];
        end
        len_next = bit_len(mor);
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        len_reg <= len_next;
        for (int i = 0; i < 3; i++) begin
            neg_reg[i] <= v[i][PW-1];
        end
    end

    // Stage B: shift so the largest magnitude lands in [2^29, 2^30).
    always_comb
    begin
        sh          = (len_reg > LW'(MW)) ? (len_reg - LW'(MW)) : (LW'(MW) - len_reg);
        o_next.zero = (len_reg == '0);
        o_next.neg  = neg_reg;
        for (int i = 0; i < 3; i++) begin
            shv[i]        = (len_reg > LW'(MW)) ? (mag_reg[i] >> sh) : (mag_reg[i] << sh);
            o_next.mag[i] = shv[i][MW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
    end

    assign o = o_reg;

endmodule

// ===== rtl/cbp_div.sv =====
module cbp_div (
    input  logic                      clk,
    input  logic [cbp_pkg::NUM_W-1:0] num,
    input  logic [cbp_pkg::DEN_W-1:0] den,
    output logic [cbp_pkg::QW-1:0]    q
);
    import cbp_pkg::*;

    logic [NUM_W-1:0] rem_in [QW];
    logic [DEN_W-1:0] den_in [QW];
    logic [QW-1:0]    q_in   [QW];
    logic [NUM_W-1:0] rem_reg [QW-1];
    logic [DEN_W-1:0] den_reg [QW-1];
    logic [QW-1:0]    q_reg  [QW];

    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign q_in[0]   = '0;

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [NUM_W-1:0] dsh;
        logic             ge;

        assign dsh = NUM_W'(den_in[j]) << (QW - 1 - j);
        assign ge  = (rem_in[j] >= dsh);

        always_ff @(posedge clk)
        begin
            q_reg[j] <= ge ? (q_in[j] | (QW'(1) << (QW - 1 - j))) : q_in[j];
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? (rem_in[j] - dsh) : rem_in[j];
                den_reg[j] <= den_in[j];
            end
            assign rem_in[j+1] = rem_reg[j];
            assign den_in[j+1] = den_reg[j];
            assign q_in[j+1]   = q_reg[j];
        end
    end

    assign q = q_reg[QW-1];

endmodule

// ===== rtl/cbp_offset.sv =====
module cbp_offset (
    input  logic                     clk,
    input  cbp_pkg::nvec_t           v,
    input  logic [cbp_pkg::KK_W-1:0] kk,
    output cbp_pkg::off_t            off [3]
);
    import cbp_pkg::*;

    logic [2*MW-1:0]         sq_reg [3];
    logic [2:0][MW-1:0]      mag1_reg;
    logic [2:0]              neg1_reg;
    logic [SQ_W-1:0]         x_reg   [0:SQRT_STAGES-1];
    logic [SQ_W-1:0]         res_reg [0:SQRT_STAGES];
    logic [2:0][MW-1:0]      mag_q   [0:SQRT_STAGES];
    logic [2:0]              neg_q   [0:SQRT_STAGES];
    logic [MW+KK_W-1:0]      num_reg [3];
    logic [LEN_W-1:0]        len_m_reg;
    logic [2:0]              neg_m_reg;
    logic [NUM_W-1:0]        nn_reg [3];
    logic [DEN_W-1:0]        den_reg;
    logic [2:0]              neg_d [QW+1];
    logic [QW-1:0]           q [3];
    logic [QW:0]             qx [3];

    // Squares, then their sum.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            sq_reg[i] <= v.mag[i] * v.mag[i];
        end
        mag1_reg   <= v.mag;
        neg1_reg   <= v.neg;
        x_reg[0]   <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        res_reg[0] <= '0;
        mag_q[0]   <= mag1_reg;
        neg_q[0]   <= neg1_reg;
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic [SQ_W-1:0] trial;
        logic            take;

        assign trial = res_reg[k] + BIT;
        assign take  = (x_reg[k] >= trial);

        always_ff @(posedge clk)
        begin
            res_reg[k+1] <= take ? ((res_reg[k] >> 1) + BIT) : (res_reg[k] >> 1);
            mag_q[k+1]   <= mag_q[k];
            neg_q[k+1]   <= neg_q[k];
        end

        if (k < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                x_reg[k+1] <= take ? (x_reg[k] - trial) : x_reg[k];
            end
        end
    end

    // Scale by bond length and trig constant, add the rounding half.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            num_reg[i] <= mag_q[SQRT_STAGES][i] * kk;
        end
        len_m_reg <= res_reg[SQRT_STAGES][LEN_W-1:0];
        neg_m_reg <= neg_q[SQRT_STAGES];
        for (int i = 0; i < 3; i++) begin
            nn_reg[i] <= NUM_W'(num_reg[i]) + NUM_W'({len_m_reg, (K_W - 1)'(0)});
        end
        den_reg  <= {len_m_reg, K_W'(0)};
        neg_d[0] <= neg_m_reg;
        for (int k = 1; k <= QW; k++) begin
            neg_d[k] <= neg_d[k-1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        cbp_div u_div (
            .clk (clk),
            .num (nn_reg[i]),
            .den (den_reg),
            .q   (q[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            qx[i]  = {1'b0, q[i]};
            off[i] = neg_d[QW][i] ? off_t'(~qx[i] + 1'b1) : off_t'(qx[i]);
        end
    end

endmodule

// ===== rtl/cbp_checker.sv =====
`include "beta_carbon_placement_top_assert.svh"

module cbp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input logic            degenerate,
    input cbp_pkg::coord_t n_x,
    input cbp_pkg::coord_t n_y,
    input cbp_pkg::coord_t n_z,
    input cbp_pkg::coord_t ca_x,
    input cbp_pkg::coord_t ca_y,
    input cbp_pkg::coord_t ca_z,
    input cbp_pkg::coord_t c_x,
    input cbp_pkg::coord_t c_y,
    input cbp_pkg::coord_t c_z,
    input cbp_pkg::coord_t cb_x,
    input cbp_pkg::coord_t cb_y,
    input cbp_pkg::coord_t cb_z
);
    import cbp_pkg::*;

    // Every result beat traces back to an accepted input beat.
    `CBP_ASSERT_IMP(a_done_has_beat, done, $past(start && !busy, LAT),
                    "result beat without input beat")

    // A degenerate residue returns its CA unchanged.
    `CBP_ASSERT_IMP(a_degen_gives_ca, done && degenerate,
                    (cb_x == $past(ca_x, LAT)) && (cb_y == $past(ca_y, LAT)) &&
                    (cb_z == $past(ca_z, LAT)),
                    "degenerate result differs from CA")

    // N on top of C leaves no cross product.
    `CBP_ASSERT_IMP(a_colinear_degen,
                    done && $past((n_x == c_x) && (n_y == c_y) && (n_z == c_z), LAT),
                    degenerate, "coincident N and C not flagged")

    // The pipeline never refuses a beat.
    `CBP_ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind beta_carbon_placement_top cbp_checker u_cbp_checker (.*);

// ===== verif/beta_carbon_placement_top_test.sv =====
`timescale 1ns / 100ps

module beta_carbon_placement_top_test;
    import cbp_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  PIPE_DEPTH  = 55;       // start-to-done latency of the block
    localparam int  PHASE_ITEMS = 240;      // five bond settings, about 1200 beats total
    localparam logic [63:0] COS_K = 64'd37837;
    localparam logic [63:0] SIN_K = 64'd53510;
    localparam logic [ADDR_W-1:0] ADDR_BOND   = {REG_BOND_LENGTH, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    // One residue and, for directed rows, the CB position read straight off the geometry.
    typedef struct {
        coord_t n [3];
        coord_t ca[3];
        coord_t c [3];
        bit     known;
        coord_t cb[3];
        bit     deg;
    } residue_t;

    typedef struct {
        coord_t cb[3];
        bit     deg;
    } cb_pos_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    coord_t          n_x, n_y, n_z, ca_x, ca_y, ca_z, c_x, c_y, c_z;
    logic            done;
    coord_t          cb_x, cb_y, cb_z;
    logic            degenerate;
    logic            psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic            pready;

    logic [11:0]     bond_q;                // our copy of the bond_length register
    cb_pos_t         cb_queue[$];           // CB positions still owed by the pipeline
    residue_t        residue_table[$];
    int              mismatch_count = 0;
    bit              no_gaps;

    beta_carbon_placement_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .n_x        (n_x),
        .n_y        (n_y),
        .n_z        (n_z),
        .ca_x       (ca_x),
        .ca_y       (ca_y),
        .ca_z       (ca_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .done       (done),
        .cb_x       (cb_x),
        .cb_y       (cb_y),
        .cb_z       (cb_z),
        .degenerate (degenerate),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run, long gaps included.
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // CB predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Shift right on the magnitude, keep the sign (truncate toward zero).
    function automatic longint shift_mag(input longint v, input int r);
        logic [63:0] m;
        m = abs64(v) >> r;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Scale so the largest magnitude sits in [2^29, 2^30); zero vector returns 0.
    function automatic bit scale_dir(input longint v[3], output longint o[3]);
        logic [63:0] m;
        int r, l;
        m = 0;
        r = 0;
        l = 0;
        foreach (v[i])
            if (abs64(v[i]) > m)
                m = abs64(v[i]);
        if (m == 0)
            return 1'b0;
        while ((m >> r) >= (64'd1 << 30))
            r++;
        while ((m << l) < (64'd1 << 29))
            l++;
        foreach (v[i])
            o[i] = shift_mag(v[i], r) * longint'(64'd1 << l);
        return 1'b1;
    endfunction

    // Offset along a scaled direction: v * bond * k / (|v| * 2^16), rounded half away.
    function automatic void bond_offset(input longint v[3], input logic [63:0] k,
                                        output longint off[3]);
        logic [63:0] sq, den, kk, num;
        sq = 0;
        foreach (v[i])
            sq += abs64(v[i]) * abs64(v[i]);
        den = int_sqrt(sq) << 16;
        kk  = 64'(bond_q) * k;
        foreach (v[i])
        begin
            num    = (abs64(v[i]) * kk + den / 2) / den;
            off[i] = v[i] < 0 ? -longint'(num) : longint'(num);
        end
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return coord_t'(v);
    endfunction

    function automatic cb_pos_t place_cb(input residue_t r);
        cb_pos_t     e;
        longint      a[3], b[3], s[3], p[3], ns[3], np[3], os[3], op[3];
        logic [63:0] m;
        int          sh;
        m  = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'(r.ca[i]) - longint'(r.n[i]);
            b[i] = longint'(r.ca[i]) - longint'(r.c[i]);
            s[i] = a[i] + b[i];
            if (abs64(a[i]) > m) m = abs64(a[i]);
            if (abs64(b[i]) > m) m = abs64(b[i]);
        end
        // Wide differences get brought below 2^30 before the cross product.
        while ((m >> sh) >= (64'd1 << 30))
            sh++;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = shift_mag(a[i], sh);
            b[i] = shift_mag(b[i], sh);
        end
        p[0] = a[1] * b[2] - a[2] * b[1];
        p[1] = a[2] * b[0] - a[0] * b[2];
        p[2] = a[0] * b[1] - a[1] * b[0];
        if (!scale_dir(s, ns) || !scale_dir(p, np))
        begin
            // Flat or folded-back geometry: CB falls on CA.
            for (int i = 0; i < 3; i++)
                e.cb[i] = r.ca[i];
            e.deg = 1'b1;
            return e;
        end
        bond_offset(ns, COS_K, os);
        bond_offset(np, SIN_K, op);
        for (int i = 0; i < 3; i++)
            e.cb[i] = clamp_coord(longint'(r.ca[i]) + os[i] + op[i]);
        e.deg = 1'b0;
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        cb_pos_t e;
        if (rst_n && done)
        begin
            if (cb_queue.size() == 0)
            begin
                report_mismatch("CB beat with nothing outstanding");
            end
            else
            begin
                e = cb_queue.pop_front();
                if (cb_x !== e.cb[0])
                    report_mismatch($sformatf("cb_x %0d, want %0d", cb_x, e.cb[0]));
                if (cb_y !== e.cb[1])
                    report_mismatch($sformatf("cb_y %0d, want %0d", cb_y, e.cb[1]));
                if (cb_z !== e.cb[2])
                    report_mismatch($sformatf("cb_z %0d, want %0d", cb_z, e.cb[2]));
                if (degenerate !== e.deg)
                    report_mismatch($sformatf("degenerate %0b, want %0b", degenerate, e.deg));
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_BOND)
            bond_q = data[11:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check_bond();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BOND;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[11:0] !== bond_q)
            report_mismatch($sformatf("bond_length reads %0d, want %0d", prdata[11:0], bond_q));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_cycles();
        int d;
        if (no_gaps)
            return 0;
        d = $urandom_range(0, 99);
        if (d < 60) return 0;
        if (d < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one residue at the falling edge, hold until accepted, then log its CB.
    task automatic send_residue(input residue_t r);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        n_x  <= r.n[0];  n_y  <= r.n[1];  n_z  <= r.n[2];
        ca_x <= r.ca[0]; ca_y <= r.ca[1]; ca_z <= r.ca[2];
        c_x  <= r.c[0];  c_y  <= r.c[1];  c_z  <= r.c[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.known)
        begin
            cb_pos_t e;
            e.cb = r.cb;
            e.deg = r.deg;
            cb_queue.push_back(e);
        end
        else
        begin
            cb_queue.push_back(place_cb(r));
        end
        gap = gap_cycles();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic drop_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Hold off until the pipeline has drained, then let it settle.
    task automatic drain_pipe();
        drop_start();
        while (cb_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic residue_t make_residue(input coord_t n[3], input coord_t ca[3],
                                              input coord_t c[3]);
        residue_t r;
        r.n = n;
        r.ca = ca;
        r.c = c;
        r.known = 1'b0;
        r.cb = ca;
        r.deg = 1'b0;
        return r;
    endfunction

    // Known-answer row: geometry is flat, so CB must land on CA.
    function automatic residue_t flat_residue(input coord_t n[3], input coord_t ca[3],
                                              input coord_t c[3]);
        residue_t r;
        r = make_residue(n, ca, c);
        r.known = 1'b1;
        r.deg = 1'b1;
        return r;
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t near_coord(input coord_t base, input int spread);
        return coord_t'(longint'(base) + $urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic residue_t random_residue();
        coord_t n[3], ca[3], c[3], d[3];
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = any_coord();
            d[i]  = coord_t'($urandom_range(0, 3200) - 1600);
        end
        if (kind < 70)
        begin
            // Realistic backbone: N and C about 1.5 A from CA.
            for (int i = 0; i < 3; i++)
            begin
                n[i] = near_coord(ca[i], 1600);
                c[i] = near_coord(ca[i], 1600);
            end
        end
        else if (kind < 76)
        begin
            // Folded back: N and C mirror each other through CA.
            for (int i = 0; i < 3; i++)
            begin
                n[i] = coord_t'(longint'(ca[i]) + d[i]);
                c[i] = coord_t'(longint'(ca[i]) - d[i]);
            end
        end
        else if (kind < 82)
        begin
            // Collinear: C twice as far along the same line.
            for (int i = 0; i < 3; i++)
            begin
                n[i] = coord_t'(longint'(ca[i]) + d[i]);
                c[i] = coord_t'(longint'(ca[i]) + 2 * d[i]);
            end
        end
        else if (kind < 88)
        begin
            // CA pinned near a rail so the offset saturates.
            for (int i = 0; i < 3; i++)
            begin
                ca[i] = $urandom_range(0, 1)
                        ? coord_t'(longint'(COORD_MAX) - $urandom_range(0, 3000))
                        : coord_t'(longint'(COORD_MIN) + $urandom_range(0, 3000));
                n[i]  = near_coord(ca[i], 1600);
                c[i]  = near_coord(ca[i], 1600);
            end
        end
        else
        begin
            // Noise across the whole coordinate range.
            for (int i = 0; i < 3; i++)
            begin
                n[i] = any_coord();
                c[i] = any_coord();
            end
        end
        return make_residue(n, ca, c);
    endfunction

    task automatic build_directed();
        coord_t z[3], hi[3], lo[3], p1[3], p2[3], p3[3];
        for (int i = 0; i < 3; i++)
        begin
            z[i]  = '0;
            hi[i] = COORD_MAX;
            lo[i] = COORD_MIN;
        end
        p1 = '{coord_t'(1024), coord_t'(0), coord_t'(0)};
        p2 = '{coord_t'(0), coord_t'(0), coord_t'(0)};
        p3 = '{coord_t'(0), coord_t'(1024), coord_t'(0)};
        // All atoms on one point: zero sum and zero cross product.
        residue_table.push_back(flat_residue(z, z, z));
        residue_table.push_back(flat_residue(hi, hi, hi));
        residue_table.push_back(flat_residue(lo, lo, lo));
        // N and C mirrored through CA: zero sum.
        residue_table.push_back(flat_residue(p1, p2, '{coord_t'(-1024), coord_t'(0), coord_t'(0)}));
        // Collinear atoms: zero cross product.
        residue_table.push_back(flat_residue(p1, p2, '{coord_t'(2048), coord_t'(0), coord_t'(0)}));
        residue_table.push_back(flat_residue(lo, z, hi));
        // Plain right angle at the origin and textbook geometry.
        residue_table.push_back(make_residue(p1, p2, p3));
        residue_table.push_back(make_residue('{coord_t'(-1470), coord_t'(0), coord_t'(0)},
                                             z,
                                             '{coord_t'(520), coord_t'(1460), coord_t'(0)}));
        // Widest differences in every direction.
        residue_table.push_back(make_residue(hi, lo, '{COORD_MAX, COORD_MIN, COORD_MAX}));
        residue_table.push_back(make_residue(lo, hi, '{COORD_MIN, COORD_MAX, COORD_MIN}));
        residue_table.push_back(make_residue('{COORD_MAX, COORD_MIN, coord_t'(0)}, z,
                                             '{coord_t'(0), COORD_MAX, COORD_MIN}));
        // CA on the rails, bond pointing out: saturation both ways.
        residue_table.push_back(make_residue('{coord_t'(COORD_MAX - 1024), COORD_MAX, COORD_MAX},
                                             hi,
                                             '{COORD_MAX, coord_t'(COORD_MAX - 1024), COORD_MAX}));
        residue_table.push_back(make_residue('{coord_t'(COORD_MIN + 1024), COORD_MIN, COORD_MIN},
                                             lo,
                                             '{COORD_MIN, coord_t'(COORD_MIN + 1024), COORD_MIN}));
        // Tiny vectors: one LSB apart.
        residue_table.push_back(make_residue('{coord_t'(1), coord_t'(0), coord_t'(0)}, z,
                                             '{coord_t'(0), coord_t'(1), coord_t'(0)}));
        residue_table.push_back(make_residue('{coord_t'(-1), coord_t'(0), coord_t'(0)}, z,
                                             '{coord_t'(0), coord_t'(0), coord_t'(-1)}));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [11:0] bond_plan[5];
        rst_n   = 1'b0;
        start   = 1'b0;
        {n_x, n_y, n_z, ca_x, ca_y, ca_z, c_x, c_y, c_z} = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        bond_q  = BOND_RESET;
        no_gaps = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset value first, then both extremes, a random bond, back to typical, and a bond of one.
        apb_check_bond();
        build_directed();
        foreach (residue_table[i])
            send_residue(residue_table[i]);
        drain_pipe();

        bond_plan = '{12'd0, 12'd4095, 12'($urandom_range(1, 4094)), 12'd1567, 12'd1};
        foreach (bond_plan[ph])
        begin
            apb_write(ADDR_BOND, {$urandom} & ~32'hFFF | 32'(bond_plan[ph]));
            // Writes to an unmapped register must leave bond_length alone.
            apb_write(ADDR_UNUSED, $urandom);
            apb_check_bond();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Alternate stretches of full-rate streaming with gappy traffic.
                if (k % 60 == 0)
                    no_gaps = $urandom_range(0, 2) == 0;
                send_residue(random_residue());
            end
            drain_pipe();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cbp_pkg.sv
rtl/cbp_front.sv
rtl/cbp_norm.sv
rtl/cbp_div.sv
rtl/cbp_offset.sv
rtl/beta_carbon_placement_top.sv
rtl/cbp_checker.sv
verif/beta_carbon_placement_top_test.sv
